// ----- hdl/prew_pkg.sv -----
package prew_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int PIXEL_BITS = 8;

    // Column counters index the line stores; size values reach the maximum itself.
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int W_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int OROW_BITS = $clog2(MAX_HEIGHT);
    localparam int H_BITS    = $clog2(MAX_HEIGHT + 1);
    localparam int IROW_BITS = H_BITS;

    // Gradient arithmetic
    localparam int SUM_BITS  = PIXEL_BITS + 2;
    localparam int GRAD_BITS = SUM_BITS + 1;
    localparam int MAG_BITS  = SUM_BITS + 1;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam int THR_BITS      = 8;

    localparam logic [THR_BITS-1:0]      RST_THRESHOLD = THR_BITS'(0);
    localparam logic [CFG_DATA_BITS-1:0] RST_WIDTH     = CFG_DATA_BITS'(640);
    localparam logic [CFG_DATA_BITS-1:0] RST_HEIGHT    = CFG_DATA_BITS'(480);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                  mode;
        logic [PIXEL_BITS-1:0] pixel;
    } t_in_word;

    typedef struct packed {
        logic [MAG_BITS-1:0] magnitude;
        logic                edge_res;
        logic                last_of_frame;
    } t_out_word;

    // Position of the pixel a word completes, relative to the image border
    typedef struct packed {
        logic has_out;
        logic no_top;
        logic no_bottom;
        logic no_left;
        logic no_right;
        logic last;
    } t_pos_flags;

    // Window entry r*3+c holds row r (top first), column c (left first)
    typedef logic [8:0][PIXEL_BITS-1:0] t_window;

endpackage

// ----- hdl/prewitt_edge_threshold.sv -----
// Channel | Direction | Handshake                   | Word
// in      | input     | i_in_valid / o_in_ready     | t_in_word  {mode, pixel}
// out     | output    | o_out_valid / i_out_ready   | t_out_word {magnitude, edge_res,
//         |           |                             |             last_of_frame}
// cfg     | input     | i_cfg_wr_en (no wait)       | i_cfg_index, i_cfg_wdata
//
// Cycles: one word per clock unless back-pressure fills the stages; a result passes the
// line-store read, the window update, the gradient stage and the magnitude stage before
// it leaves the output register.
// Reset: synchronous, active low; clears counters, window and stage valids. The line
// stores are not cleared; entries read before being written only reach masked taps.
// Stalls: every stage holds on its own, so input flows while bubbles remain downstream.
module prewitt_edge_threshold
    import prew_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_word                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_word                o_out_data,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    localparam int RAM_WIDTH = 2 * PIXEL_BITS;

    // Stage 1: word accepted, line-store read in flight
    logic                  r_s1_valid;
    logic [PIXEL_BITS-1:0] r_s1_px;
    logic [COL_BITS-1:0]   r_s1_idx;
    t_pos_flags            r_s1_flags;
    logic                  r_s1_fwd;
    logic [PIXEL_BITS-1:0] r_s1_fwd_up;
    logic [PIXEL_BITS-1:0] r_s1_fwd_mid;

    // Stage 2: window holds the neighborhood of a pixel with a result
    logic                  r_s2_valid;
    t_pos_flags            r_s2_flags;
    t_window               r_window;

    logic                  accept;
    logic                  s1_adv;
    logic                  rdy2;
    logic                  grad_ready;
    logic [PIXEL_BITS-1:0] px;
    logic [COL_BITS-1:0]   scan_idx;
    t_pos_flags            scan_flags;
    logic [THR_BITS-1:0]   threshold;
    logic [RAM_WIDTH-1:0]  ram_rd_data;
    logic [PIXEL_BITS-1:0] up1;
    logic [PIXEL_BITS-1:0] mid1;

    // Ready ripples back from the output register; an empty stage always takes a word
    assign rdy2       = !r_s2_valid || grad_ready;
    assign s1_adv     = r_s1_valid && rdy2;
    assign o_in_ready = !r_s1_valid || rdy2;
    assign accept     = i_in_valid && o_in_ready;

    // Flush words act as zero pixels
    assign px = i_in_data.mode ? '0 : i_in_data.pixel;

    prew_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (accept),
        .o_idx       (scan_idx),
        .o_flags     (scan_flags),
        .o_threshold (threshold)
    );

    // Upper store in the high byte, middle store in the low byte; both share a column
    prew_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (RAM_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_idx),
        .i_wr_data ({mid1, r_s1_px}),
        .i_rd_en   (accept),
        .i_rd_addr (scan_idx),
        .o_rd_data (ram_rd_data)
    );

    // Take the forwarded column when the read raced the write-back of the same entry
    assign up1  = r_s1_fwd ? r_s1_fwd_up  : ram_rd_data[RAM_WIDTH-1:PIXEL_BITS];
    assign mid1 = r_s1_fwd ? r_s1_fwd_mid : ram_rd_data[PIXEL_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px      <= px;
            r_s1_idx     <= scan_idx;
            r_s1_flags   <= scan_flags;
            r_s1_fwd     <= s1_adv && (r_s1_idx == scan_idx);
            r_s1_fwd_up  <= mid1;
            r_s1_fwd_mid <= r_s1_px;
        end
    end

    // Advance the window on every word; only words with a result occupy stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_window   <= '0;
        end else begin
            if (s1_adv) begin
                r_s2_valid <= r_s1_flags.has_out;
            end else if (grad_ready) begin
                r_s2_valid <= 1'b0;
            end
            if (s1_adv) begin
                for (int r = 0; r < 3; r++) begin
                    r_window[r * 3]     <= r_window[r * 3 + 1];
                    r_window[r * 3 + 1] <= r_window[r * 3 + 2];
                end
                r_window[2] <= up1;
                r_window[5] <= mid1;
                r_window[8] <= r_s1_px;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_flags <= r_s1_flags;
        end
    end

    prew_grad u_grad (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s2_valid),
        .o_ready     (grad_ready),
        .i_window    (r_window),
        .i_flags     (r_s2_flags),
        .i_threshold (threshold),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- hdl/prew_ram.sv -----
module prew_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/prew_scan.sv -----
module prew_scan
    import prew_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                     i_adv,
    output logic [COL_BITS-1:0]      o_idx,
    output t_pos_flags               o_flags,
    output logic [THR_BITS-1:0]      o_threshold
);

    logic [THR_BITS-1:0]      r_threshold;
    logic [CFG_DATA_BITS-1:0] r_width;
    logic [CFG_DATA_BITS-1:0] r_height;

    logic [COL_BITS-1:0]  r_in_col,  n_in_col;
    logic [IROW_BITS-1:0] r_in_row,  n_in_row;
    logic [COL_BITS-1:0]  r_out_col, n_out_col;
    logic [OROW_BITS-1:0] r_out_row, n_out_row;

    logic [W_BITS-1:0] w_eff;
    logic [H_BITS-1:0] h_eff;
    logic              col_wrap;
    t_pos_flags        flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RST_THRESHOLD;
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_THRESHOLD: r_threshold <= i_cfg_wdata[THR_BITS-1:0];
                CFG_WIDTH:     r_width     <= i_cfg_wdata;
                CFG_HEIGHT:    r_height    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Zero counts as one, oversize saturates
    always_comb begin
        if (r_width == '0) begin
            w_eff = W_BITS'(1);
        end else if ({1'b0, r_width} > (CFG_DATA_BITS + 1)'(MAX_WIDTH)) begin
            w_eff = W_BITS'(MAX_WIDTH);
        end else begin
            w_eff = W_BITS'(r_width);
        end
        if (r_height == '0) begin
            h_eff = H_BITS'(1);
        end else if ({1'b0, r_height} > (CFG_DATA_BITS + 1)'(MAX_HEIGHT)) begin
            h_eff = H_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = H_BITS'(r_height);
        end
    end

    always_comb begin
        col_wrap = (W_BITS'(r_in_col) + W_BITS'(1)) >= w_eff;

        // A result exists once a row plus one pixel has gone in
        if (r_in_row == '0) begin
            flags.has_out = W_BITS'(r_in_col) > w_eff;
        end else if (r_in_row == IROW_BITS'(1)) begin
            flags.has_out = r_in_col != '0;
        end else begin
            flags.has_out = 1'b1;
        end
        flags.no_top    = r_out_row == '0;
        flags.no_bottom = (H_BITS'(r_out_row) + H_BITS'(1)) >= h_eff;
        flags.no_left   = r_out_col == '0;
        flags.no_right  = (W_BITS'(r_out_col) + W_BITS'(1)) >= w_eff;
        flags.last      = flags.no_bottom && flags.no_right;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (col_wrap) begin
            n_in_col = '0;
            n_in_row = r_in_row + IROW_BITS'(1);
        end else begin
            n_in_col = r_in_col + COL_BITS'(1);
        end
        if (flags.has_out) begin
            if (flags.last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (flags.no_right) begin
                n_out_col = '0;
                n_out_row = r_out_row + OROW_BITS'(1);
            end else begin
                n_out_col = r_out_col + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_adv) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    assign o_idx       = r_in_col;
    assign o_flags     = flags;
    assign o_threshold = r_threshold;

endmodule

// ----- hdl/prew_grad.sv -----
module prew_grad
    import prew_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_window             i_window,
    input  t_pos_flags          i_flags,
    input  logic [THR_BITS-1:0] i_threshold,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_word           o_out_data
);

    logic                        r_s3_valid;
    logic signed [GRAD_BITS-1:0] r_gx;
    logic signed [GRAD_BITS-1:0] r_gy;
    logic                        r_last;
    logic                        r_out_valid;
    t_out_word                   r_out_data;

    logic                        rdy_out;
    logic                        rdy3;
    logic                        s3_adv;
    logic                        s2_adv;
    t_window                     v;
    logic [SUM_BITS-1:0]         sum_left, sum_right, sum_top, sum_bottom;
    logic signed [GRAD_BITS-1:0] gx, gy;
    logic [SUM_BITS-1:0]         abs_x, abs_y;
    logic [MAG_BITS-1:0]         mag;

    assign rdy_out = !r_out_valid || i_out_ready;
    assign rdy3    = !r_s3_valid || rdy_out;
    assign s3_adv  = r_s3_valid && rdy_out;
    assign s2_adv  = i_valid && rdy3;
    assign o_ready = rdy3;

    // Zero the taps that fall outside the image
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            if (((k / 3) == 0 && i_flags.no_top) || ((k / 3) == 2 && i_flags.no_bottom) ||
                ((k % 3) == 0 && i_flags.no_left) || ((k % 3) == 2 && i_flags.no_right)) begin
                v[k] = '0;
            end else begin
                v[k] = i_window[k];
            end
        end
        sum_left   = SUM_BITS'(v[0]) + SUM_BITS'(v[3]) + SUM_BITS'(v[6]);
        sum_right  = SUM_BITS'(v[2]) + SUM_BITS'(v[5]) + SUM_BITS'(v[8]);
        sum_top    = SUM_BITS'(v[0]) + SUM_BITS'(v[1]) + SUM_BITS'(v[2]);
        sum_bottom = SUM_BITS'(v[6]) + SUM_BITS'(v[7]) + SUM_BITS'(v[8]);
        gx = $signed(GRAD_BITS'(sum_right)) - $signed(GRAD_BITS'(sum_left));
        gy = $signed(GRAD_BITS'(sum_bottom)) - $signed(GRAD_BITS'(sum_top));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s2_adv) begin
            r_s3_valid <= 1'b1;
        end else if (s3_adv) begin
            r_s3_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_gx   <= gx;
            r_gy   <= gy;
            r_last <= i_flags.last;
        end
    end

    always_comb begin
        abs_x = r_gx[GRAD_BITS-1] ? SUM_BITS'(-r_gx) : SUM_BITS'(r_gx);
        abs_y = r_gy[GRAD_BITS-1] ? SUM_BITS'(-r_gy) : SUM_BITS'(r_gy);
        mag   = MAG_BITS'(abs_x) + MAG_BITS'(abs_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s3_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_adv) begin
            r_out_data.magnitude     <= mag;
            r_out_data.edge_res      <= mag >= MAG_BITS'(i_threshold);
            r_out_data.last_of_frame <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- tb/prewitt_checker.sv -----
`timescale 1ns / 100ps

module prewitt_checker
    import prew_pkg::*;
#(
    parameter logic FLUSH_MODE = 1'b1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  t_in_word                 i_in_data,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  t_out_word                i_out_data,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    output int                       o_mismatches,
    output int                       o_pending,
    output logic                     o_frame_start
);

    logic [THR_BITS-1:0]      thr_reg;
    logic [CFG_DATA_BITS-1:0] width_reg;
    logic [CFG_DATA_BITS-1:0] height_reg;

    logic [PIXEL_BITS-1:0] upper_line  [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] middle_line [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] nbhd        [9];
    int unsigned           in_col;
    int unsigned           in_row;
    int unsigned           out_col;
    int unsigned           out_row;

    t_out_word edge_q [$];

    function automatic int unsigned clamp_dim(input logic [CFG_DATA_BITS-1:0] v,
                                              input int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Shift one word into the window and queue the result it completes, if any.
    task automatic predict_edge(input t_in_word word);
        int unsigned           w;
        int unsigned           h;
        int unsigned           col;
        int unsigned           pos;
        int unsigned           mag;
        logic [PIXEL_BITS-1:0] px;
        logic [PIXEL_BITS-1:0] up;
        logic [PIXEL_BITS-1:0] mid;
        logic                  no_top;
        logic                  no_bottom;
        logic                  no_left;
        logic                  no_right;
        int                    tap [9];
        int                    gx;
        int                    gy;
        int                    r;
        int                    c;
        t_out_word             res;

        w   = clamp_dim(width_reg, MAX_WIDTH);
        h   = clamp_dim(height_reg, MAX_HEIGHT);
        col = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
        px  = (word.mode == FLUSH_MODE) ? '0 : word.pixel;
        up  = upper_line[col];
        mid = middle_line[col];
        upper_line[col]  = mid;
        middle_line[col] = px;
        for (r = 0; r < 3; r++) begin
            nbhd[r*3]   = nbhd[r*3+1];
            nbhd[r*3+1] = nbhd[r*3+2];
        end
        nbhd[2] = up;
        nbhd[5] = mid;
        nbhd[8] = px;

        pos = in_row * w + in_col;
        if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
        end else begin
            in_col++;
        end
        if (pos < w + 1)
            return;

        no_top    = (out_row == 0);
        no_bottom = (out_row + 1 >= h);
        no_left   = (out_col == 0);
        no_right  = (out_col + 1 >= w);
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                tap[r*3+c] = ((r == 0 && no_top) || (r == 2 && no_bottom) ||
                              (c == 0 && no_left) || (c == 2 && no_right)) ?
                             0 : int'(nbhd[r*3+c]);
        gx  = (tap[2] + tap[5] + tap[8]) - (tap[0] + tap[3] + tap[6]);
        gy  = (tap[6] + tap[7] + tap[8]) - (tap[0] + tap[1] + tap[2]);
        mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);

        res.magnitude     = MAG_BITS'(mag);
        res.edge_res      = (mag >= thr_reg);
        res.last_of_frame = no_bottom && no_right;
        edge_q.push_back(res);

        if (res.last_of_frame) begin
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        end else if (no_right) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endtask

    task automatic check_result(input t_out_word got);
        t_out_word want;

        if (edge_q.size() == 0) begin
            if (o_mismatches < 10)
                $display("%0t: unexpected result magnitude %0d edge %0b last %0b",
                         $realtime, got.magnitude, got.edge_res, got.last_of_frame);
            o_mismatches++;
            return;
        end
        want = edge_q.pop_front();
        if (got.magnitude !== want.magnitude || got.edge_res !== want.edge_res ||
            got.last_of_frame !== want.last_of_frame) begin
            if (o_mismatches < 10)
                $display("%0t: result mismatch, expected mag %0d edge %0b last %0b, %s",
                         $realtime, want.magnitude, want.edge_res, want.last_of_frame,
                         $sformatf("got mag %0d edge %0b last %0b",
                                   got.magnitude, got.edge_res, got.last_of_frame));
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        int k;

        if (!i_rst_n) begin
            thr_reg    = RST_THRESHOLD;
            width_reg  = RST_WIDTH;
            height_reg = RST_HEIGHT;
            for (k = 0; k < MAX_WIDTH; k++) begin
                upper_line[k]  = '0;
                middle_line[k] = '0;
            end
            for (k = 0; k < 9; k++)
                nbhd[k] = '0;
            in_col       = 0;
            in_row       = 0;
            out_col      = 0;
            out_row      = 0;
            o_mismatches = 0;
            edge_q.delete();
        end else begin
            // compare before predicting: no word may come out in the cycle it enters
            if (i_out_valid && i_out_ready)
                check_result(i_out_data);
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_THRESHOLD: thr_reg    = i_cfg_wdata[THR_BITS-1:0];
                    CFG_WIDTH:     width_reg  = i_cfg_wdata;
                    CFG_HEIGHT:    height_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_edge(i_in_data);
        end
        o_pending     = edge_q.size();
        o_frame_start = (in_col == 0) && (in_row == 0);
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import prew_pkg::*;

    localparam logic MODE_PIXEL    = 1'b0;
    localparam logic MODE_FLUSH    = 1'b1;
    // leave margin after the last expected result for stray output
    localparam int   SETTLE_CYCLES = 16;
    localparam int   HOLD_CYCLES   = 300;
    localparam int   RANDOM_WORDS  = 550;
    localparam int   NO_STOP       = 1 << 30;

    logic                     i_clk     = 1'b0;
    logic                     i_rst_n   = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    t_in_word                 in_data   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    t_out_word                out_data;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    // Flow control knobs, driven by the stimulus process
    logic steady    = 1'b0;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    int   mismatches;
    int   pending;
    logic frame_start;
    int   words_sent = 0;

    prewitt_edge_threshold u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    prewitt_checker #(
        .FLUSH_MODE (MODE_FLUSH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_frame_start (frame_start)
    );

    always #5 i_clk = ~i_clk;

    // Output side: random back-pressure, a steady mode, and one long hold-off
    // that lets the pipeline fill and stall the input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= steady || ($urandom_range(99) >= 31);
        end
    end

    // Mostly random values, with the extremes showing up often
    function automatic logic [PIXEL_BITS-1:0] random_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return PIXEL_BITS'($urandom_range(255));
        endcase
    endfunction

    // Write all three registers on back-to-back cycles; call only while idle.
    task automatic write_setup(input logic [THR_BITS-1:0]      thr,
                               input logic [CFG_DATA_BITS-1:0] w,
                               input logic [CFG_DATA_BITS-1:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_THRESHOLD;
        cfg_wdata <= CFG_DATA_BITS'(thr);
        @(posedge i_clk);
        cfg_index <= CFG_WIDTH;
        cfg_wdata <= w;
        @(posedge i_clk);
        cfg_index <= CFG_HEIGHT;
        cfg_wdata <= h;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one word and hold it until accepted. Random gaps go in front of
    // the word, so valid never drops while a word is pending.
    task automatic push_word(input logic mode, input logic [PIXEL_BITS-1:0] px);
        t_in_word word;

        word.mode  = mode;
        word.pixel = px;
        if (!steady)
            while ($urandom_range(99) < 31) begin
                in_valid <= 1'b0;
                @(posedge i_clk);
            end
        in_valid <= 1'b1;
        in_data  <= word;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        words_sent++;
    endtask

    // A frame is w*h pixel words and w+1 flush words; noise swaps the kind of
    // a word at the given percentage. Stop early after stop_after words.
    task automatic send_frame(input int w, input int h, input int noise,
                              input int stop_after);
        int   total;
        int   k;
        logic mode;

        total = w * h + w + 1;
        for (k = 0; k < total && k < stop_after; k++) begin
            if (k < w * h)
                mode = ($urandom_range(99) < noise) ? MODE_FLUSH : MODE_PIXEL;
            else
                mode = ($urandom_range(99) < noise) ? MODE_PIXEL : MODE_FLUSH;
            push_word(mode, random_pixel());
        end
    endtask

    // Drive flush words one at a time until the block is back at a frame
    // start; read the predicted position at the falling edge.
    task automatic finish_frame();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (!frame_start) begin
            @(posedge i_clk);
            push_word(MODE_FLUSH, random_pixel());
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // Drop valid, wait for every expected word, then let the pipeline settle.
    // Read the count at a falling edge so the last accepted word is counted.
    task automatic drain_all();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int k;
        int frame_no;
        int w_cfg;
        int h_cfg;
        int w_eff;
        int h_eff;
        int noise;
        logic [THR_BITS-1:0] thr;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x3 frame: bright lower-right corner gives the largest magnitude at
        // the center. The first word is a flush inside the frame and must act
        // as a zero pixel; one flush slot carries a pixel that must be masked.
        write_setup(8'd255, 12'd3, 12'd3);
        for (k = 0; k < 9; k++) begin
            if (k == 0)
                push_word(MODE_FLUSH, 8'hFF);
            else
                push_word(MODE_PIXEL, ((k / 3 + k % 3) >= 3) ? 8'hFF : 8'h00);
        end
        for (k = 0; k < 4; k++)
            push_word((k == 1) ? MODE_PIXEL : MODE_FLUSH, 8'hFF);
        drain_all();

        // Width zero reads as one column; height zero reads as one row
        write_setup(8'd0, 12'd0, 12'd2);
        send_frame(1, 2, 0, NO_STOP);
        drain_all();
        write_setup(8'd128, 12'd2, 12'd0);
        send_frame(2, 1, 0, NO_STOP);
        drain_all();

        // Random frames: mostly well formed, some with swapped word kinds,
        // some with the size changed halfway through.
        words_sent = 0;
        frame_no   = 0;
        while (words_sent < RANDOM_WORDS) begin
            case ($urandom_range(5))
                0:       thr = '0;
                1:       thr = '1;
                default: thr = THR_BITS'($urandom_range(255));
            endcase
            w_cfg = $urandom_range(0, 12);
            h_cfg = $urandom_range(0, 8);
            if (frame_no == 2) begin
                // big frame behind the long output hold-off; its twelve columns
                // also fill every line store entry a later size change reaches
                w_cfg = 12;
                h_cfg = 8;
                hold_req <= 1'b1;
            end
            steady <= (frame_no >= 5 && frame_no < 9);
            w_eff = (w_cfg == 0) ? 1 : w_cfg;
            h_eff = (h_cfg == 0) ? 1 : h_cfg;
            write_setup(thr, CFG_DATA_BITS'(w_cfg), CFG_DATA_BITS'(h_cfg));
            if (frame_no % 7 == 6) begin
                send_frame(w_eff, h_eff, 0, $urandom_range(1, w_eff * h_eff));
                drain_all();
                write_setup(THR_BITS'($urandom_range(255)),
                            CFG_DATA_BITS'($urandom_range(1, 12)),
                            CFG_DATA_BITS'($urandom_range(1, 8)));
                finish_frame();
            end else begin
                noise = ($urandom_range(99) < 25) ? 15 : 0;
                send_frame(w_eff, h_eff, noise, NO_STOP);
            end
            drain_all();
            frame_no++;
        end

        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/prew_pkg.sv
hdl/prew_ram.sv
hdl/prew_scan.sv
hdl/prew_grad.sv
hdl/prewitt_edge_threshold.sv
tb/prewitt_checker.sv
tb/testbench.sv
